// ===== design/ptt_pkg.sv =====
`default_nettype none
package ptt_pkg;

    localparam int POS_W   = 32;
    localparam int QUAT_W  = 16;
    localparam int COST_W  = 48;
    localparam int SCALE_W = 10;
    localparam int SPEED_W = 24;
    localparam int YAW_W   = 18;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_DEPTH = 32;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_COST_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_LINEAR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INV_ANGULAR = 2'd2;

    localparam logic [SCALE_W-1:0] COST_SCALE_RST  = 10'd10;
    localparam logic [SPEED_W-1:0] INV_LINEAR_RST  = 24'd218453;
    localparam logic [SPEED_W-1:0] INV_ANGULAR_RST = 24'd125163;

    localparam logic signed [YAW_W-1:0] HALF_PI_Q15 = 18'sd51472;
    localparam logic signed [19:0]      PI_Q15      = 20'sd102944;
    localparam logic signed [19:0]      TWO_PI_Q15  = 20'sd205887;
    localparam logic [23:0]             INV_GAIN_Q24 = 24'd10188014;
    localparam logic [COST_W-1:0]       MAX48 = {COST_W{1'b1}};

    typedef logic signed [POS_W-1:0]  pos_t;
    typedef logic signed [QUAT_W-1:0] quat_t;
    typedef logic [COST_W-1:0]        cost_t;

    // Arctangent of 2^-i in Q.15 radians.
    function automatic logic [15:0] atan_q15(input logic [4:0] idx);
        logic [15:0] r;
        case (idx)
            5'd0:    r = 16'd25736;
            5'd1:    r = 16'd15193;
            5'd2:    r = 16'd8027;
            5'd3:    r = 16'd4075;
            5'd4:    r = 16'd2045;
            5'd5:    r = 16'd1024;
            5'd6:    r = 16'd512;
            5'd7:    r = 16'd256;
            5'd8:    r = 16'd128;
            5'd9:    r = 16'd64;
            5'd10:   r = 16'd32;
            5'd11:   r = 16'd16;
            5'd12:   r = 16'd8;
            5'd13:   r = 16'd4;
            5'd14:   r = 16'd2;
            5'd15:   r = 16'd1;
            default: r = 16'd0;
        endcase
        return r;
    endfunction

endpackage
`default_nettype wire

// ===== design/ptt_pose_if.sv =====
`default_nettype none
interface ptt_pose_if;
    import ptt_pkg::*;

    logic  valid;
    logic  ready;
    pos_t  pos_x;
    pos_t  pos_y;
    quat_t quat_x;
    quat_t quat_y;
    quat_t quat_z;
    quat_t quat_w;
    logic  last_pose;

    modport source (output valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w, last_pose,
                    input ready);
    modport sink (input valid, pos_x, pos_y, quat_x, quat_y, quat_z, quat_w, last_pose,
                  output ready);
endinterface
`default_nettype wire

// ===== design/ptt_cost_if.sv =====
`default_nettype none
interface ptt_cost_if;
    import ptt_pkg::*;

    logic  valid;
    logic  ready;
    cost_t plan_cost;
    logic  cost_saturated;

    modport source (output valid, plan_cost, cost_saturated, input ready);
    modport sink (input valid, plan_cost, cost_saturated, output ready);
endinterface
`default_nettype wire

// ===== design/ptt_cfg_if.sv =====
`default_nettype none
interface ptt_cfg_if;
    import ptt_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== design/path_travel_time_cost_core.sv =====
`default_nettype none
// Travel-time cost of a planned path. Poses arrive one beat at a time on the
// pose channel; the first pose of a path only becomes the reference, and each
// later pose adds max(distance * inv_linear_speed, |yaw change| *
// inv_angular_speed) to a saturating Q32.16 sum. The beat marked last_pose
// yields one beat on the cost channel with cost_scale times the sum, and the
// path state is cleared. A single CORDIC datapath, run CORDIC_STEPS times per
// use, serves both the yaw arctangent and the distance magnitude, and one
// shared multiplier handles the gain correction and the two speed products.
// The pose channel is not ready while a pose is in work. Configuration
// writes are always taken and must only be issued while the block is idle.
module path_travel_time_cost_core #(
    parameter int CORDIC_STEPS = ptt_pkg::CORDIC_STEPS_DEF
)(
    input  wire logic clk,
    input  wire logic rst_n,
    ptt_pose_if.sink   pose,
    ptt_cost_if.source cost,
    ptt_cfg_if.sink    cfg
);
    import ptt_pkg::*;

    localparam int CW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam int DW = 36;  // CORDIC datapath width
    localparam logic [CW-1:0] LAST_STEP = CW'(CORDIC_STEPS - 1);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_PROD = 4'd1;
    localparam logic [3:0] ST_PREP = 4'd2;
    localparam logic [3:0] ST_ROT  = 4'd3;
    localparam logic [3:0] ST_GAIN = 4'd4;
    localparam logic [3:0] ST_LIN  = 4'd5;
    localparam logic [3:0] ST_ANG  = 4'd6;
    localparam logic [3:0] ST_ACC  = 4'd7;
    localparam logic [3:0] ST_FIN  = 4'd8;

    // Configuration registers.
    logic [SCALE_W-1:0] scale_reg;
    logic [SPEED_W-1:0] inv_lin_reg;
    logic [SPEED_W-1:0] inv_ang_reg;

    // Control state.
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] cnt_reg;
    logic          mag_mode_reg;
    logic          have_prev_reg;
    logic          sum_sat_reg;
    logic          out_valid_reg;

    // Payload registers.
    pos_t  px_reg, py_reg, prev_x_reg, prev_y_reg;
    logic  last_reg;
    quat_t qx_reg, qy_reg, qz_reg, qw_reg;
    logic signed [31:0] p_wz_reg, p_xy_reg, p_ww_reg, p_xx_reg, p_yy_reg, p_zz_reg;
    logic signed [DW-1:0]    cx_reg, cy_reg;
    logic signed [YAW_W-1:0] cz_reg;
    logic                    zero_vec_reg;
    logic signed [YAW_W-1:0] yaw_reg, prev_yaw_reg;
    logic [34:0]   dist_reg;
    logic [42:0]   tlin_reg, tang_reg;
    logic [COST_W-1:0] sum_reg;
    logic [COST_W-1:0] out_cost_reg;
    logic              out_sat_reg;

    // Preparation of the atan2 arguments.
    logic signed [33:0] num, den;
    // CORDIC step.
    logic signed [DW-1:0]    xs, ys;
    logic signed [YAW_W-1:0] atan_ext;
    logic                    rot_pos;
    logic [15:0]             atan_val;
    logic signed [YAW_W-1:0] yaw_final;
    // Magnitude operands.
    logic signed [32:0] dx, dy;
    logic [32:0]        adx, ady;
    // Yaw change.
    logic signed [19:0] dyaw, dwrap;
    logic [16:0]        dabs;
    // Shared multiplier.
    logic [34:0] mul_a;
    logic [23:0] mul_b;
    logic [58:0] mul_p;
    // Accumulate and final product.
    logic [42:0]   seg;
    logic [COST_W:0] sum_wide;
    logic [57:0]   prod;

    assign pose.ready = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;
    assign cost.valid = out_valid_reg;
    assign cost.plan_cost = out_cost_reg;
    assign cost.cost_saturated = out_sat_reg;

    always_comb
    begin
        num = 34'(2) * (34'(p_wz_reg) + 34'(p_xy_reg));
        den = 34'(p_ww_reg) + 34'(p_xx_reg) - 34'(p_yy_reg) - 34'(p_zz_reg);
    end

    always_comb
    begin
        xs = cx_reg >>> cnt_reg;
        ys = cy_reg >>> cnt_reg;
        rot_pos = (cy_reg > 0);
        atan_val = atan_q15(5'(cnt_reg));
        atan_ext = YAW_W'($signed({1'b0, atan_val}));
        yaw_final = rot_pos ? cz_reg + atan_ext : cz_reg - atan_ext;
        if (zero_vec_reg)
        begin
            yaw_final = '0;
        end
    end

    always_comb
    begin
        dx = 33'(prev_x_reg) - 33'(px_reg);
        dy = 33'(prev_y_reg) - 33'(py_reg);
        adx = dx[32] ? 33'(-dx) : 33'(dx);
        ady = dy[32] ? 33'(-dy) : 33'(dy);
    end

    always_comb
    begin
        dyaw = 20'(yaw_reg) - 20'(prev_yaw_reg);
        if (dyaw > PI_Q15)
        begin
            dwrap = dyaw - TWO_PI_Q15;
        end
        else if (dyaw < -PI_Q15)
        begin
            dwrap = dyaw + TWO_PI_Q15;
        end
        else
        begin
            dwrap = dyaw;
        end
        dabs = dwrap[19] ? 17'(-dwrap) : 17'(dwrap);
    end

    // One multiplier serves the gain correction and both speed products.
    always_comb
    begin
        case (state_reg)
            ST_GAIN:
            begin
                mul_a = cx_reg[DW-1] ? '0 : cx_reg[34:0];
                mul_b = INV_GAIN_Q24;
            end
            ST_LIN:
            begin
                mul_a = dist_reg;
                mul_b = inv_lin_reg;
            end
            default:
            begin
                mul_a = 35'(dabs);
                mul_b = inv_ang_reg;
            end
        endcase
        mul_p = 59'(mul_a) * 59'(mul_b);
    end

    always_comb
    begin
        seg = (tlin_reg > tang_reg) ? tlin_reg : tang_reg;
        sum_wide = {1'b0, sum_reg} + (COST_W+1)'(seg);
        prod = 58'(sum_reg) * 58'(scale_reg);
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (pose.valid) state_next = ST_PROD;
            ST_PROD: state_next = ST_PREP;
            ST_PREP: state_next = ST_ROT;
            ST_ROT:
            begin
                if (cnt_reg == LAST_STEP)
                begin
                    if (mag_mode_reg)
                    begin
                        state_next = ST_GAIN;
                    end
                    else if (have_prev_reg)
                    begin
                        state_next = ST_ROT;
                    end
                    else
                    begin
                        state_next = last_reg ? ST_FIN : ST_IDLE;
                    end
                end
            end
            ST_GAIN: state_next = ST_LIN;
            ST_LIN:  state_next = ST_ANG;
            ST_ANG:  state_next = ST_ACC;
            ST_ACC:  state_next = last_reg ? ST_FIN : ST_IDLE;
            ST_FIN:  if (!out_valid_reg || cost.ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            mag_mode_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            sum_sat_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            prev_x_reg    <= '0;
            prev_y_reg    <= '0;
            prev_yaw_reg  <= '0;
            scale_reg     <= COST_SCALE_RST;
            inv_lin_reg   <= INV_LINEAR_RST;
            inv_ang_reg   <= INV_ANGULAR_RST;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_COST_SCALE:  scale_reg   <= cfg.data[SCALE_W-1:0];
                    REG_INV_LINEAR:  inv_lin_reg <= cfg.data[SPEED_W-1:0];
                    REG_INV_ANGULAR: inv_ang_reg <= cfg.data[SPEED_W-1:0];
                    default: ;
                endcase
            end

            // A new cost beat may replace the one leaving in the same cycle.
            if (state_reg == ST_FIN && (!out_valid_reg || cost.ready))
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && cost.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_PREP:
                begin
                    cnt_reg <= '0;
                    mag_mode_reg <= 1'b0;
                end
                ST_ROT:
                begin
                    cnt_reg <= (cnt_reg == LAST_STEP) ? '0 : cnt_reg + 1'b1;
                    if (cnt_reg == LAST_STEP && !mag_mode_reg)
                    begin
                        if (have_prev_reg)
                        begin
                            mag_mode_reg <= 1'b1;
                        end
                        else
                        begin
                            prev_x_reg    <= px_reg;
                            prev_y_reg    <= py_reg;
                            prev_yaw_reg  <= yaw_final;
                            have_prev_reg <= 1'b1;
                        end
                    end
                end
                ST_ACC:
                begin
                    if (sum_wide[COST_W])
                    begin
                        sum_reg     <= MAX48;
                        sum_sat_reg <= 1'b1;
                    end
                    else
                    begin
                        sum_reg <= sum_wide[COST_W-1:0];
                    end
                    prev_x_reg   <= px_reg;
                    prev_y_reg   <= py_reg;
                    prev_yaw_reg <= yaw_reg;
                end
                ST_FIN:
                begin
                    if (!out_valid_reg || cost.ready)
                    begin
                        have_prev_reg <= 1'b0;
                        sum_sat_reg   <= 1'b0;
                        sum_reg       <= '0;
                        prev_x_reg    <= '0;
                        prev_y_reg    <= '0;
                        prev_yaw_reg  <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (pose.valid)
                begin
                    px_reg   <= pose.pos_x;
                    py_reg   <= pose.pos_y;
                    qx_reg   <= pose.quat_x;
                    qy_reg   <= pose.quat_y;
                    qz_reg   <= pose.quat_z;
                    qw_reg   <= pose.quat_w;
                    last_reg <= pose.last_pose;
                end
            end
            ST_PROD:
            begin
                p_wz_reg <= qw_reg * qz_reg;
                p_xy_reg <= qx_reg * qy_reg;
                p_ww_reg <= qw_reg * qw_reg;
                p_xx_reg <= qx_reg * qx_reg;
                p_yy_reg <= qy_reg * qy_reg;
                p_zz_reg <= qz_reg * qz_reg;
            end
            ST_PREP:
            begin
                // Rotate by a quarter turn when the vector lies in the left half plane.
                zero_vec_reg <= (num == 0) && (den == 0);
                if (den < 0)
                begin
                    if (num >= 0)
                    begin
                        cx_reg <= DW'(num);
                        cy_reg <= -DW'(den);
                        cz_reg <= HALF_PI_Q15;
                    end
                    else
                    begin
                        cx_reg <= -DW'(num);
                        cy_reg <= DW'(den);
                        cz_reg <= -HALF_PI_Q15;
                    end
                end
                else
                begin
                    cx_reg <= DW'(den);
                    cy_reg <= DW'(num);
                    cz_reg <= '0;
                end
            end
            ST_ROT:
            begin
                if (cnt_reg == LAST_STEP && !mag_mode_reg && have_prev_reg)
                begin
                    // Yaw is done; reload the same datapath for the distance.
                    yaw_reg <= yaw_final;
                    cx_reg  <= DW'($signed({1'b0, adx}));
                    cy_reg  <= DW'($signed({1'b0, ady}));
                end
                else if (rot_pos)
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= yaw_final;
                end
                else
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= yaw_final;
                end
            end
            ST_GAIN: dist_reg <= mul_p[58:24];
            ST_LIN:  tlin_reg <= mul_p[58:16];
            ST_ANG:  tang_reg <= mul_p[57:15];
            ST_FIN:
            begin
                if (!out_valid_reg || cost.ready)
                begin
                    if (prod[57:COST_W] != '0)
                    begin
                        out_cost_reg <= MAX48;
                        out_sat_reg  <= 1'b1;
                    end
                    else
                    begin
                        out_cost_reg <= prod[COST_W-1:0];
                        out_sat_reg  <= sum_sat_reg;
                    end
                end
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

// ===== verif/path_travel_time_cost_core_test.sv =====
`default_nettype none
// Self-checking bench for the path travel-time cost core.
module path_travel_time_cost_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ptt_pkg::*;

    // The unused register slot. A write to it must leave every register alone.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int LATENCY_PAUSE = 60;
    localparam int LONG_HOLD = 400;

    typedef struct packed {
        pos_t  pos_x;
        pos_t  pos_y;
        quat_t quat_x;
        quat_t quat_y;
        quat_t quat_z;
        quat_t quat_w;
        logic  last_pose;
    } pose_t;

    typedef struct packed {
        cost_t cost;
        logic  sat;
    } cost_beat_t;

    // One row of the directed table. When typed is set, the cost beat that the
    // path must produce is written into the row instead of being predicted.
    typedef struct packed {
        pose_t      pose;
        logic       typed;
        cost_beat_t want;
    } pose_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ptt_pose_if pose ();
    ptt_cost_if cost ();
    ptt_cfg_if  cfg ();

    path_travel_time_cost_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pose  (pose.sink),
        .cost  (cost.source),
        .cfg   (cfg.sink)
    );

    always #2 clk = ~clk;

    // Arctangent of 2^-i in Q.15 radians, as the datapath steps through it.
    longint atan_step [16] = '{25736, 15193, 8027, 4075, 2045, 1024, 512, 256,
                               128, 64, 32, 16, 8, 4, 2, 1};

    // Mirror of the registers and of the path state that the core keeps.
    longint unsigned scale_reg;
    longint unsigned inv_lin_reg;
    longint unsigned inv_ang_reg;
    longint          last_x;
    longint          last_y;
    longint          last_yaw;
    bit              have_last;
    longint unsigned path_time;
    bit              path_time_sat;

    cost_beat_t cost_due_q [$];
    pose_row_t  sent_note_q [$];

    int mismatches = 0;
    int snd_idle_pct = 20;
    int rcv_idle_pct = 67;
    bit hold_req = 1'b0;
    int hold_cnt = 0;

    // Rotates (x, y) onto the x axis, accumulating the angle in z.
    function automatic void cordic_vector(inout longint x, inout longint y, inout longint z);
        longint xs;
        longint ys;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys;
                y -= xs;
                z += atan_step[i];
            end
            else begin
                x -= ys;
                y += xs;
                z -= atan_step[i];
            end
        end
    endfunction

    // Advances the mirrored path state by one pose; a last pose yields a cost.
    function automatic void step_path(input pose_t p, output bit has_cost,
                                      output cost_beat_t beat);
        longint qx;
        longint qy;
        longint qz;
        longint qw;
        longint x;
        longint y;
        longint z;
        longint t;
        longint yaw;
        longint d;
        longint unsigned seg_len;
        longint unsigned t_lin;
        longint unsigned t_ang;
        longint unsigned prod;
        qx = p.quat_x;
        qy = p.quat_y;
        qz = p.quat_z;
        qw = p.quat_w;
        y = 2 * (qw * qz + qx * qy);
        x = qw * qw + qx * qx - qy * qy - qz * qz;
        z = 0;
        if (x == 0 && y == 0) begin
            yaw = 0;
        end
        else begin
            // Bring a left-half vector into the right half before the loop.
            if (x < 0) begin
                t = x;
                if (y >= 0) begin
                    x = y;
                    y = -t;
                    z = HALF_PI_Q15;
                end
                else begin
                    x = -y;
                    y = t;
                    z = -HALF_PI_Q15;
                end
            end
            cordic_vector(x, y, z);
            yaw = z;
        end

        if (have_last) begin
            d = yaw - last_yaw;
            if (d > PI_Q15)
                d -= TWO_PI_Q15;
            else if (d < -PI_Q15)
                d += TWO_PI_Q15;
            if (d < 0)
                d = -d;
            x = last_x - longint'(p.pos_x);
            y = last_y - longint'(p.pos_y);
            if (x < 0)
                x = -x;
            if (y < 0)
                y = -y;
            z = 0;
            cordic_vector(x, y, z);
            if (x < 0)
                x = 0;
            seg_len = (longint'(unsigned'(x)) * longint'(INV_GAIN_Q24)) >> 24;
            t_lin = (seg_len * inv_lin_reg) >> 16;
            t_ang = (longint'(unsigned'(d)) * inv_ang_reg) >> 15;
            path_time += (t_lin > t_ang) ? t_lin : t_ang;
            if (path_time > longint'(MAX48)) begin
                path_time = MAX48;
                path_time_sat = 1'b1;
            end
        end
        last_x = p.pos_x;
        last_y = p.pos_y;
        last_yaw = yaw;
        have_last = 1'b1;

        has_cost = p.last_pose;
        beat = '0;
        if (p.last_pose) begin
            prod = path_time * scale_reg;
            beat.sat = path_time_sat;
            if (prod > longint'(MAX48)) begin
                prod = MAX48;
                beat.sat = 1'b1;
            end
            beat.cost = prod[COST_W-1:0];
            last_x = 0;
            last_y = 0;
            last_yaw = 0;
            have_last = 1'b0;
            path_time = 0;
            path_time_sat = 1'b0;
        end
    endfunction

    // All handshakes are observed at the falling edge: the core only changes
    // its outputs at the rising edge, so a beat seen with valid and ready high
    // here is the one that completes at the next rising edge.
    always @(negedge clk) begin
        pose_row_t  note;
        bit         has_cost;
        cost_beat_t beat;
        cost_beat_t due;
        if (rst_n) begin
            if (pose.valid && pose.ready) begin
                note = sent_note_q.pop_front();
                step_path(note.pose, has_cost, beat);
                if (has_cost)
                    cost_due_q.push_back(note.typed ? note.want : beat);
            end
            if (cost.valid && cost.ready) begin
                if (cost_due_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected cost beat: cost %0d sat %0b",
                                 cost.plan_cost, cost.cost_saturated);
                end
                else begin
                    due = cost_due_q.pop_front();
                    if (cost.plan_cost !== due.cost || cost.cost_saturated !== due.sat) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("cost mismatch: expected %0d sat %0b, got %0d sat %0b",
                                     due.cost, due.sat, cost.plan_cost, cost.cost_saturated);
                    end
                end
            end
        end
    end

    // The receiver stalls at random, or for a long stretch on request so that
    // the core fills up and has to hold off the pose channel.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            cost.ready <= 1'b0;
        end
        else begin
            if (hold_req) begin
                hold_cnt = LONG_HOLD;
                hold_req = 1'b0;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                cost.ready <= 1'b0;
            end
            else begin
                cost.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
            end
        end
    end

    // Offers one pose, with a random gap first, and returns once it is taken.
    task automatic send_pose(input pose_t p, input bit typed = 1'b0,
                             input cost_beat_t want = '0);
        pose_row_t note;
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            pose.valid <= 1'b0;
            @(posedge clk);
        end
        note.pose = p;
        note.typed = typed;
        note.want = want;
        sent_note_q.push_back(note);
        pose.valid <= 1'b1;
        pose.pos_x <= p.pos_x;
        pose.pos_y <= p.pos_y;
        pose.quat_x <= p.quat_x;
        pose.quat_y <= p.quat_y;
        pose.quat_z <= p.quat_z;
        pose.quat_w <= p.quat_w;
        pose.last_pose <= p.last_pose;
        do
            @(negedge clk);
        while (!pose.ready);
        @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        do
            @(negedge clk);
        while (!cfg.ready);
        @(posedge clk);
        cfg.valid <= 1'b0;
        case (idx)
            REG_COST_SCALE:  scale_reg = val[SCALE_W-1:0];
            REG_INV_LINEAR:  inv_lin_reg = val[SPEED_W-1:0];
            REG_INV_ANGULAR: inv_ang_reg = val[SPEED_W-1:0];
            default: ;
        endcase
    endtask

    // Waits until every cost beat is in, then gives the core time to finish
    // whatever pose it may still be chewing on.
    task automatic wait_idle();
        pose.valid <= 1'b0;
        while (cost_due_q.size() != 0 || sent_note_q.size() != 0)
            @(posedge clk);
        repeat (LATENCY_PAUSE) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] pick_reg_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return CFG_DATA_W'(1);
            2: return '1;
            3: return CFG_DATA_W'($urandom_range(0, 1023));
            default: return CFG_DATA_W'($urandom);
        endcase
    endfunction

    function automatic quat_t pick_quat();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 16'sh7fff;
            2: return 16'sh8000;
            default: return QUAT_W'($urandom);
        endcase
    endfunction

    // Random paths: mostly short walks with small steps, now and then a jump
    // anywhere in the position range.
    task automatic run_random_paths(input int count);
        int    sent;
        int    len;
        pose_t p;
        sent = 0;
        p = '0;
        while (sent < count) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 6);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    p.pos_x = $urandom;
                    p.pos_y = $urandom;
                end
                else begin
                    p.pos_x = p.pos_x + $urandom_range(0, 1 << 21) - (1 << 20);
                    p.pos_y = p.pos_y + $urandom_range(0, 1 << 21) - (1 << 20);
                end
                p.quat_x = pick_quat();
                p.quat_y = pick_quat();
                p.quat_z = pick_quat();
                p.quat_w = pick_quat();
                p.last_pose = (k == len - 1);
                send_pose(p);
                sent++;
            end
        end
    endtask

    function automatic pose_t mk_pose(input pos_t x, input pos_t y, input quat_t qx,
                                      input quat_t qy, input quat_t qz, input quat_t qw,
                                      input logic last);
        pose_t p;
        p.pos_x = x;
        p.pos_y = y;
        p.quat_x = qx;
        p.quat_y = qy;
        p.quat_z = qz;
        p.quat_w = qw;
        p.last_pose = last;
        return p;
    endfunction

    pose_row_t directed [$];

    initial begin
        pose_t p;
        pose.valid = 1'b0;
        pose.pos_x = '0;
        pose.pos_y = '0;
        pose.quat_x = '0;
        pose.quat_y = '0;
        pose.quat_z = '0;
        pose.quat_w = '0;
        pose.last_pose = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;
        scale_reg = COST_SCALE_RST;
        inv_lin_reg = INV_LINEAR_RST;
        inv_ang_reg = INV_ANGULAR_RST;
        last_x = 0;
        last_y = 0;
        last_yaw = 0;
        have_last = 1'b0;
        path_time = 0;
        path_time_sat = 1'b0;

        // A pose alone on its path costs nothing.
        directed.push_back('{mk_pose(0, 0, 0, 0, 0, 16'sh7fff, 1), 1'b1, '{'0, 1'b0}});
        // Two identical poses: no distance and no turn.
        directed.push_back('{mk_pose(32'sh12345, -32'sh777, 0, 0, 16'sh1000, 16'sh7000, 0),
                             1'b0, '0});
        directed.push_back('{mk_pose(32'sh12345, -32'sh777, 0, 0, 16'sh1000, 16'sh7000, 1),
                             1'b1, '{'0, 1'b0}});
        // An all-zero quaternion has yaw zero, so standing still is free.
        directed.push_back('{mk_pose(-5, 9, 0, 0, 0, 0, 0), 1'b0, '0});
        directed.push_back('{mk_pose(-5, 9, 0, 0, 0, 0, 1), 1'b1, '{'0, 1'b0}});
        // Corners of the position range and extreme quaternion components.
        directed.push_back('{mk_pose(32'sh80000000, 32'sh80000000, 0, 0, 0, 16'sh8000, 0),
                             1'b0, '0});
        directed.push_back('{mk_pose(32'sh7fffffff, 32'sh7fffffff, 16'sh7fff, 0, 0, 0, 0),
                             1'b0, '0});
        directed.push_back('{mk_pose(32'sh80000000, 32'sh7fffffff, 0, 16'sh7fff, 0, 0, 0),
                             1'b0, '0});
        directed.push_back('{mk_pose(32'sh7fffffff, 32'sh80000000, 16'sh8000, 16'sh8000,
                                     16'sh8000, 16'sh8000, 1), 1'b0, '0});
        // Yaw near +pi then near -pi: the change must wrap to a small turn.
        directed.push_back('{mk_pose(0, 0, 0, 0, 16'sh7fff, 16'sh0010, 0), 1'b0, '0});
        directed.push_back('{mk_pose(0, 0, 0, 0, 16'sh7fff, -16'sh0010, 0), 1'b0, '0});
        // Pure turn in place, then a pure move, each side of the max.
        directed.push_back('{mk_pose(0, 0, 0, 0, 16'sh5a82, 16'sh5a82, 0), 1'b0, '0});
        directed.push_back('{mk_pose(32'sh30000, -32'sh40000, 0, 0, 16'sh5a82, 16'sh5a82, 0),
                             1'b0, '0});
        directed.push_back('{mk_pose(32'sh30000, -32'sh40000, 16'sh7fff, 16'sh7fff,
                                     16'sh7fff, 16'sh7fff, 1), 1'b0, '0});

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset register values.
        foreach (directed[i])
            send_pose(directed[i].pose, directed[i].typed, directed[i].want);
        wait_idle();

        // Extreme registers. Scale gets all data bits set to check masking,
        // and the unused slot is written to check that it changes nothing.
        write_reg(REG_COST_SCALE, '1);
        write_reg(REG_INV_LINEAR, '1);
        write_reg(REG_INV_ANGULAR, '1);
        write_reg(REG_UNUSED, '0);
        // One long corner-to-corner jump overflows the scaled product.
        send_pose(mk_pose(32'sh80000000, 32'sh80000000, 0, 0, 0, 16'sh7fff, 0));
        send_pose(mk_pose(32'sh7fffffff, 32'sh7fffffff, 0, 0, 0, 16'sh7fff, 1));
        // Bouncing between corners long enough saturates the running sum.
        for (int k = 0; k < 200; k++) begin
            p = mk_pose((k % 2) ? 32'sh7fffffff : 32'sh80000000,
                        (k % 2) ? 32'sh7fffffff : 32'sh80000000,
                        0, 0, 0, 16'sh7fff, k == 199);
            send_pose(p);
        end
        wait_idle();

        // Zero registers: nothing costs anything.
        write_reg(REG_COST_SCALE, '0);
        write_reg(REG_INV_LINEAR, '0);
        write_reg(REG_INV_ANGULAR, '0);
        run_random_paths(40);
        wait_idle();

        // Random part, three idling patterns, two register settings each.
        for (int mode = 0; mode < 3; mode++) begin
            snd_idle_pct = (mode == 0) ? 20 : (mode == 1) ? 67 : 0;
            rcv_idle_pct = (mode == 0) ? 67 : (mode == 1) ? 20 : 0;
            for (int sub = 0; sub < 2; sub++) begin
                write_reg(REG_COST_SCALE, pick_reg_value());
                write_reg(REG_INV_LINEAR, pick_reg_value());
                write_reg(REG_INV_ANGULAR, pick_reg_value());
                if (mode == 0 && sub == 0)
                    hold_req = 1'b1;
                run_random_paths(200);
                wait_idle();
            end
        end

        // Back to the reset values for a last short stretch.
        write_reg(REG_COST_SCALE, COST_SCALE_RST);
        write_reg(REG_INV_LINEAR, INV_LINEAR_RST);
        write_reg(REG_INV_ANGULAR, INV_ANGULAR_RST);
        run_random_paths(40);
        wait_idle();

        if (mismatches == 0 && cost_due_q.size() == 0)
            $display("path_travel_time_cost_core_test passed");
        else
            $display("path_travel_time_cost_core_test failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("path_travel_time_cost_core_test failed");
        $finish;
    end

endmodule
`default_nettype wire
